FILE: hw/rtl/mbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbt_pkg;

    // Number format: signed Q8.24 in one 32-bit word.
    localparam int DATA_W = 32;
    localparam int Q_FRAC = 24;
    localparam logic signed [31:0] Q_ONE = 32'sd16777216;

    // Default sizes of the network.
    localparam int HIDDEN_LAYERS_DEF = 2;
    localparam int MAX_WIDTH_DEF = 16;

    // Item operations.
    localparam logic [1:0] OP_WRITE_WEIGHT = 2'd0;
    localparam logic [1:0] OP_WRITE_BIAS   = 2'd1;
    localparam logic [1:0] OP_PREDICT      = 2'd2;
    localparam logic [1:0] OP_TRAIN        = 2'd3;

    // Configuration register indexes.
    localparam logic REG_HIDDEN_WIDTH  = 1'b0;
    localparam logic REG_LEARNING_RATE = 1'b1;

    localparam logic [4:0]  HIDDEN_WIDTH_RST  = 5'd16;
    localparam logic [24:0] LEARNING_RATE_RST = 25'd167772;

    // Clamp a wide signed value to one signed 32-bit word.
    function automatic logic signed [31:0] sat_to_word(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mlp_backprop_trainer.sv
`timescale 1ns / 1ps
`default_nettype none

// Trainer for a small perceptron: one scalar input, HIDDEN_LAYERS sigmoid
// layers and one linear output, all in signed Q8.24.
// Input channel (s_axis): one word per item holding an operation, write
// indexes, a parameter value, an input sample and a target. Output channel
// (m_axis): one word per item with the prediction, the error and a status.
// The configuration port sets the neurons in use and the learning rate;
// write it only while no item is in flight.
// Every product goes through one shared multiplier in the steps read,
// multiply, round and accumulate. The result word of an item becomes valid
// as the block returns to idle and can take the next item.
// One item is worked at a time; tready is high only when the block is idle.
// After reset a clearing pass zeroes the weight and bias memories before
// the first item is taken. A stalled receiver holds the result in the output
// register; the next item may be taken meanwhile and waits at its end until
// the register is free.
module mlp_backprop_trainer #(
    parameter int HIDDEN_LAYERS = mbt_pkg::HIDDEN_LAYERS_DEF,
    parameter int MAX_WIDTH     = mbt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // operation, layer_index, from_index, to_index, param_value, sample_x,
    // target_y, zero fill
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [111:0] i_s_axis_tdata,
    // prediction, error_value, status, zero fill
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [71:0]       o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [24:0]  i_cfg_wdata
);

    import mbt_pkg::*;

    localparam int WCount = 2 * MAX_WIDTH + (HIDDEN_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
    localparam int BCount = HIDDEN_LAYERS * MAX_WIDTH + 1;
    localparam int ACount = HIDDEN_LAYERS * MAX_WIDTH + 2;
    localparam int WA = $clog2(WCount);
    localparam int BA = $clog2(BCount);
    localparam int AA = $clog2(ACount);
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KW = $clog2(HIDDEN_LAYERS + 1);
    localparam logic [KW-1:0] KOut = KW'(HIDDEN_LAYERS);
    localparam logic [KW-1:0] KLast = KW'(HIDDEN_LAYERS - 1);

    // Sequencer states.
    localparam logic [5:0] S_CLR = 6'd0,  S_IDLE = 6'd1,  S_WR = 6'd2,   S_FB = 6'd3;
    localparam logic [5:0] S_FBW = 6'd4,  S_FRD = 6'd5,   S_FMUL = 6'd6, S_FM1 = 6'd7;
    localparam logic [5:0] S_FM2 = 6'd8,  S_FEND = 6'd9,  S_BA = 6'd10,  S_BAW = 6'd11;
    localparam logic [5:0] S_BA1 = 6'd12, S_BA2 = 6'd13,  S_BRD = 6'd14, S_BMUL = 6'd15;
    localparam logic [5:0] S_BM1 = 6'd16, S_BM2 = 6'd17,  S_BEND = 6'd18, S_BE1 = 6'd19;
    localparam logic [5:0] S_BE2 = 6'd20, S_URD = 6'd21,  S_UMUL = 6'd22, S_UM1 = 6'd23;
    localparam logic [5:0] S_UM2 = 6'd24, S_UM3 = 6'd25,  S_UM4 = 6'd26, S_UBRD = 6'd27;
    localparam logic [5:0] S_UBMUL = 6'd28, S_UB1 = 6'd29, S_UB2 = 6'd30, S_FIN = 6'd31;

    localparam logic [1:0] PH_FWD = 2'd0, PH_BWD = 2'd1, PH_UPD = 2'd2;

    function automatic logic [WA-1:0] w_addr(input int l, input int i, input int j);
        int v;
        if (l == 0) begin
            v = j;
        end else if (l == HIDDEN_LAYERS) begin
            v = MAX_WIDTH + (HIDDEN_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH + i;
        end else begin
            v = MAX_WIDTH + (l - 1) * MAX_WIDTH * MAX_WIDTH + i * MAX_WIDTH + j;
        end
        return WA'(v);
    endfunction

    function automatic logic [AA-1:0] a_addr(input int k, input int j);
        return AA'(1 + k * MAX_WIDTH + j);
    endfunction

    function automatic logic [BA-1:0] b_addr(input int l, input int j);
        int v;
        if (l < HIDDEN_LAYERS) begin
            v = l * MAX_WIDTH + j;
        end else begin
            v = HIDDEN_LAYERS * MAX_WIDTH;
        end
        return BA'(v);
    endfunction

    // Piecewise-linear sigmoid, mirrored for negative inputs.
    function automatic logic [31:0] sigmoid_pwl(input logic signed [31:0] z);
        logic [32:0] m;
        logic [32:0] y;
        m = z[31] ? 33'(-{z[31], z}) : {1'b0, z};
        if (m >= 33'd83886080) begin
            y = 33'd16777216;
        end else if (m >= 33'd39845888) begin
            y = (m >> 5) + 33'd14155776;
        end else if (m >= 33'd16777216) begin
            y = (m >> 3) + 33'd10485760;
        end else begin
            y = (m >> 2) + 33'd8388608;
        end
        if (z[31]) begin
            y = 33'd16777216 - y;
        end
        return y[31:0];
    endfunction

    logic [5:0]  r_state, n_state;
    logic [1:0]  r_ph, n_ph;
    logic [WA-1:0] r_clr, n_clr;
    logic [KW-1:0] r_k, n_k;
    logic [IW-1:0] r_i, n_i, r_j, n_j;
    logic [4:0]  r_hw;
    logic [24:0] r_lr;
    logic [1:0]  r_op, n_op, r_layer, n_layer;
    logic [3:0]  r_from, n_from, r_to, n_to;
    logic signed [31:0] r_val, n_val, r_x, n_x, r_y, n_y;
    logic signed [31:0] r_pred, n_pred, r_err, n_err, r_dv, n_dv, r_w, n_w;
    logic signed [39:0] r_acc, n_acc;
    logic        r_stat, n_stat;
    logic        r_ov;
    logic signed [31:0] r_opred, r_oerr;
    logic        r_ostat;

    logic [IW-1:0] nlast, il, jl;
    logic [6:0]  hw7;
    logic signed [31:0] lr_eff, acc_sat, mac_a, mac_b, mac_q;
    logic signed [31:0] w_rdata, b_rdata, a_rdata, d_rdata, a_sel;
    logic        w_we, b_we, a_we, d_we;
    logic [WA-1:0] w_waddr, w_raddr;
    logic [BA-1:0] b_waddr, b_raddr;
    logic [AA-1:0] a_waddr, a_raddr, d_waddr, d_raddr;
    logic [31:0] w_wdata, b_wdata, a_wdata, d_wdata;
    logic        wr_ok, out_free;
    logic [KW-1:0] km1, kp1;
    logic signed [32:0] upd_diff;

    // Neurons in use and learning rate, clamped to their working ranges.
    always_comb begin
        hw7 = {2'b00, r_hw};
        if (hw7 == 7'd0) begin
            nlast = '0;
        end else if (hw7 > 7'(MAX_WIDTH)) begin
            nlast = IW'(MAX_WIDTH - 1);
        end else begin
            nlast = IW'(hw7 - 7'd1);
        end
        lr_eff = (r_lr > 25'd16777216) ? Q_ONE : {7'b0, r_lr};
    end

    assign km1 = (r_k == '0) ? '0 : r_k - KW'(1);
    assign kp1 = (r_k == KOut) ? r_k : r_k + KW'(1);
    assign acc_sat = sat_to_word({{24{r_acc[39]}}, r_acc});

    // Loop bounds of the current layer for each phase.
    always_comb begin
        il = nlast;
        jl = nlast;
        case (r_ph)
            PH_FWD, PH_UPD: begin
                il = (r_k == '0) ? '0 : nlast;
                jl = (r_k == KOut) ? '0 : nlast;
            end
            PH_BWD: begin
                il = nlast;
                jl = (r_k == KLast) ? '0 : nlast;
            end
            default: begin
                il = nlast;
                jl = nlast;
            end
        endcase
    end

    // Read addresses follow the loop counters of the current phase.
    always_comb begin
        if (r_ph == PH_BWD) begin
            w_raddr = (r_k == KLast) ? w_addr(HIDDEN_LAYERS, int'(r_i), 0)
                                     : w_addr(int'(kp1), int'(r_i), int'(r_j));
            a_raddr = a_addr(int'(r_k), int'(r_i));
            d_raddr = a_addr(int'(kp1), int'(r_j));
        end else begin
            w_raddr = w_addr(int'(r_k), int'(r_i), int'(r_j));
            a_raddr = a_addr(int'(km1), int'(r_i));
            d_raddr = a_addr(int'(r_k), int'(r_j));
        end
        b_raddr = b_addr(int'(r_k), int'(r_j));
    end

    assign a_sel = (r_k == '0) ? r_x : a_rdata;

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_a = w_rdata;
        mac_b = a_sel;
        case (r_state)
            S_FMUL: begin
                mac_a = w_rdata;
                mac_b = (r_k == '0) ? r_x : a_rdata;
            end
            S_BAW: begin
                mac_a = a_rdata;
                mac_b = Q_ONE - a_rdata;
            end
            S_BMUL: begin
                mac_a = w_rdata;
                mac_b = (r_k == KLast) ? r_err : d_rdata;
            end
            S_BEND: begin
                mac_a = acc_sat;
                mac_b = r_dv;
            end
            S_UMUL: begin
                mac_a = (r_k == KOut) ? r_err : d_rdata;
                mac_b = a_sel;
            end
            S_UM2: begin
                mac_a = lr_eff;
                mac_b = mac_q;
            end
            S_UBMUL: begin
                mac_a = lr_eff;
                mac_b = (r_k == KOut) ? r_err : d_rdata;
            end
            default: begin
                mac_a = w_rdata;
                mac_b = a_sel;
            end
        endcase
    end

    // Index check of a weight or bias write.
    always_comb begin
        wr_ok = (int'(r_layer) <= HIDDEN_LAYERS) && (int'(r_to) < MAX_WIDTH);
        if (r_op == OP_WRITE_WEIGHT) begin
            if (int'(r_from) >= MAX_WIDTH) wr_ok = 1'b0;
            if (r_layer == 2'd0 && r_from != 4'd0) wr_ok = 1'b0;
        end
        if (int'(r_layer) == HIDDEN_LAYERS && r_to != 4'd0) wr_ok = 1'b0;
    end

    assign upd_diff = {r_w[31], r_w} - {mac_q[31], mac_q};
    assign out_free = !r_ov || i_m_axis_tready;

    // Memory write ports.
    always_comb begin
        w_we = 1'b0;
        w_waddr = w_raddr;
        w_wdata = sat_to_word({{31{upd_diff[32]}}, upd_diff});
        b_we = 1'b0;
        b_waddr = b_raddr;
        b_wdata = sat_to_word({{31{upd_diff[32]}}, upd_diff});
        a_we = (r_state == S_FEND) && (r_k != KOut);
        a_waddr = a_addr(int'(r_k), int'(r_j));
        a_wdata = sigmoid_pwl(acc_sat);
        d_we = (r_state == S_BE2);
        d_waddr = a_addr(int'(r_k), int'(r_i));
        d_wdata = mac_q;
        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                b_we = (int'(r_clr) < BCount);
                b_waddr = BA'(r_clr);
                b_wdata = '0;
            end
            S_WR: begin
                w_we = wr_ok && (r_op == OP_WRITE_WEIGHT);
                w_waddr = w_addr(int'(r_layer), int'(r_from), int'(r_to));
                w_wdata = r_val;
                b_we = wr_ok && (r_op == OP_WRITE_BIAS);
                b_waddr = b_addr(int'(r_layer), int'(r_to));
                b_wdata = r_val;
            end
            S_UM4: begin
                w_we = 1'b1;
            end
            S_UB2: begin
                b_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
                b_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_ph = r_ph;
        n_clr = r_clr;
        n_k = r_k;
        n_i = r_i;
        n_j = r_j;
        n_op = r_op;
        n_layer = r_layer;
        n_from = r_from;
        n_to = r_to;
        n_val = r_val;
        n_x = r_x;
        n_y = r_y;
        n_pred = r_pred;
        n_err = r_err;
        n_dv = r_dv;
        n_w = r_w;
        n_acc = r_acc;
        n_stat = r_stat;
        case (r_state)
            S_CLR: begin
                n_clr = r_clr + WA'(1);
                if (r_clr == WA'(WCount - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op = i_s_axis_tdata[1:0];
                    n_layer = i_s_axis_tdata[3:2];
                    n_from = i_s_axis_tdata[7:4];
                    n_to = i_s_axis_tdata[11:8];
                    n_val = i_s_axis_tdata[43:12];
                    n_x = i_s_axis_tdata[75:44];
                    n_y = i_s_axis_tdata[107:76];
                    n_pred = '0;
                    n_err = '0;
                    n_stat = 1'b0;
                    n_ph = PH_FWD;
                    n_k = '0;
                    n_i = '0;
                    n_j = '0;
                    if (i_s_axis_tdata[1:0] == OP_WRITE_WEIGHT ||
                        i_s_axis_tdata[1:0] == OP_WRITE_BIAS) begin
                        n_state = S_WR;
                    end else begin
                        n_state = S_FB;
                    end
                end
            end
            S_WR: begin
                n_stat = !wr_ok;
                n_state = S_FIN;
            end
            // Forward pass: bias, then one product per source neuron.
            S_FB: n_state = S_FBW;
            S_FBW: begin
                n_acc = {{8{b_rdata[31]}}, b_rdata};
                n_i = '0;
                n_state = S_FRD;
            end
            S_FRD: n_state = S_FMUL;
            S_FMUL: n_state = S_FM1;
            S_FM1: n_state = S_FM2;
            S_FM2: begin
                n_acc = r_acc + {{8{mac_q[31]}}, mac_q};
                if (r_i == il) begin
                    n_state = S_FEND;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_FRD;
                end
            end
            S_FEND: begin
                if (r_k == KOut) begin
                    n_pred = acc_sat;
                    if (r_op == OP_TRAIN) begin
                        n_err = sat_to_word({{32{acc_sat[31]}}, acc_sat} -
                                            {{32{r_y[31]}}, r_y});
                        n_ph = PH_BWD;
                        n_k = KLast;
                        n_i = '0;
                        n_j = '0;
                        n_state = S_BA;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (r_j == jl) begin
                    n_j = '0;
                    n_k = r_k + KW'(1);
                    n_state = S_FB;
                end else begin
                    n_j = r_j + IW'(1);
                    n_state = S_FB;
                end
            end
            // Backward pass: derivative a*(1-a), weighted delta sum, product.
            S_BA: n_state = S_BAW;
            S_BAW: n_state = S_BA1;
            S_BA1: n_state = S_BA2;
            S_BA2: begin
                n_dv = mac_q;
                n_acc = '0;
                n_j = '0;
                n_state = S_BRD;
            end
            S_BRD: n_state = S_BMUL;
            S_BMUL: n_state = S_BM1;
            S_BM1: n_state = S_BM2;
            S_BM2: begin
                n_acc = r_acc + {{8{mac_q[31]}}, mac_q};
                if (r_j == jl) begin
                    n_state = S_BEND;
                end else begin
                    n_j = r_j + IW'(1);
                    n_state = S_BRD;
                end
            end
            S_BEND: n_state = S_BE1;
            S_BE1: n_state = S_BE2;
            S_BE2: begin
                if (r_i == nlast) begin
                    n_i = '0;
                    n_j = '0;
                    if (r_k == '0) begin
                        n_ph = PH_UPD;
                        n_state = S_URD;
                    end else begin
                        n_k = r_k - KW'(1);
                        n_state = S_BA;
                    end
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_BA;
                end
            end
            // Weight update: w -= lr * (d * a), then the layer's biases.
            S_URD: n_state = S_UMUL;
            S_UMUL: begin
                n_w = w_rdata;
                n_state = S_UM1;
            end
            S_UM1: n_state = S_UM2;
            S_UM2: n_state = S_UM3;
            S_UM3: n_state = S_UM4;
            S_UM4: begin
                if (r_j == jl) begin
                    n_j = '0;
                    if (r_i == il) begin
                        n_i = '0;
                        n_state = S_UBRD;
                    end else begin
                        n_i = r_i + IW'(1);
                        n_state = S_URD;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                    n_state = S_URD;
                end
            end
            S_UBRD: n_state = S_UBMUL;
            S_UBMUL: begin
                n_w = b_rdata;
                n_state = S_UB1;
            end
            S_UB1: n_state = S_UB2;
            S_UB2: begin
                if (r_j == jl) begin
                    n_j = '0;
                    if (r_k == KOut) begin
                        n_state = S_FIN;
                    end else begin
                        n_k = r_k + KW'(1);
                        n_state = S_URD;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                    n_state = S_UBRD;
                end
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ph <= PH_FWD;
            r_clr <= '0;
            r_k <= '0;
            r_i <= '0;
            r_j <= '0;
            r_hw <= HIDDEN_WIDTH_RST;
            r_lr <= LEARNING_RATE_RST;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph <= n_ph;
            r_clr <= n_clr;
            r_k <= n_k;
            r_i <= n_i;
            r_j <= n_j;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HIDDEN_WIDTH: r_hw <= i_cfg_wdata[4:0];
                    REG_LEARNING_RATE: r_lr <= i_cfg_wdata;
                    default: r_hw <= r_hw;
                endcase
            end
            if (r_state == S_FIN && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_layer <= n_layer;
        r_from <= n_from;
        r_to <= n_to;
        r_val <= n_val;
        r_x <= n_x;
        r_y <= n_y;
        r_pred <= n_pred;
        r_err <= n_err;
        r_dv <= n_dv;
        r_w <= n_w;
        r_acc <= n_acc;
        r_stat <= n_stat;
        if (r_state == S_FIN && out_free) begin
            r_opred <= r_pred;
            r_oerr <= r_err;
            r_ostat <= r_stat;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata = {7'b0, r_ostat, r_oerr, r_opred};

    mbt_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_q   (mac_q)
    );

    mbt_ram #(.WIDTH(DATA_W), .DEPTH(WCount)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mbt_ram #(.WIDTH(DATA_W), .DEPTH(BCount)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mbt_ram #(.WIDTH(DATA_W), .DEPTH(ACount)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mbt_ram #(.WIDTH(DATA_W), .DEPTH(ACount)) u_delta_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mbt_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module mbt_mac (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [31:0]      o_q
);

    import mbt_pkg::*;

    logic signed [63:0] r_p;
    logic signed [64:0] rnd;

    // Full product, then round to nearest (ties upward) and saturate.
    assign rnd = {r_p[63], r_p} + 65'sd8388608;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
        o_q <= sat_to_word({{(Q_FRAC-1){rnd[64]}}, rnd[64:Q_FRAC]});
    end

endmodule

`default_nettype wire

FILE: sim/mlp_backprop_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port, predicts each result word
// and compares it with the word that the block sends.
module mlp_backprop_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [111:0] i_s_tdata,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [71:0]  i_m_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [24:0]  i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count
);
    import mbt_pkg::*;

    localparam int NL = 2;
    localparam int MW = 16;
    localparam int NW_W = 2 * MW + (NL - 1) * MW * MW;
    localparam int NB = NL * MW + 1;
    localparam int NA = NL * MW + 2;
    localparam int OUT_SLOT = NL * MW + 1;

    typedef struct packed {
        logic        status;
        logic [31:0] err;
        logic [31:0] pred;
    } result_t;

    logic signed [31:0] weights [NW_W];
    logic signed [31:0] biases [NB];
    logic signed [31:0] acts [NA];
    logic signed [31:0] deltas [NA];
    logic [4:0]  width_reg;
    logic [24:0] rate_reg;
    result_t     expected_q [$];

    // Clamp to one signed word.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q8.24 product, rounded half upward, then clamped.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clamp32((p + 64'sd8388608) >>> 24);
    endfunction

    function automatic logic signed [31:0] sigm(input logic signed [31:0] z);
        logic signed [63:0] m;
        logic signed [63:0] y;
        m = z < 0 ? -64'(z) : 64'(z);
        if (m >= 64'sd83886080) y = 64'sd16777216;
        else if (m >= 64'sd39845888) y = m / 32 + 64'sd14155776;
        else if (m >= 64'sd16777216) y = m / 8 + 64'sd10485760;
        else y = m / 4 + 64'sd8388608;
        if (z < 0) y = 64'sd16777216 - y;
        return y[31:0];
    endfunction

    function automatic int widx(input int l, input int i, input int j);
        if (l == 0) return j;
        if (l == NL) return MW + (NL - 1) * MW * MW + i;
        return MW + (l - 1) * MW * MW + i * MW + j;
    endfunction

    function automatic int aidx(input int k, input int j);
        return 1 + k * MW + j;
    endfunction

    function automatic int neurons_in_use();
        if (width_reg == 0) return 1;
        if (width_reg > MW) return MW;
        return width_reg;
    endfunction

    function automatic logic signed [31:0] forward_pass(input logic signed [31:0] x,
                                                        input int nw);
        logic signed [63:0] acc;
        acts[0] = x;
        for (int k = 0; k < NL; k++) begin
            for (int j = 0; j < nw; j++) begin
                acc = 64'(biases[k * MW + j]);
                if (k == 0) begin
                    acc += 64'(qmul(weights[widx(0, 0, j)], x));
                end else begin
                    for (int i = 0; i < nw; i++) begin
                        acc += 64'(qmul(weights[widx(k, i, j)], acts[aidx(k - 1, i)]));
                    end
                end
                acts[aidx(k, j)] = sigm(clamp32(acc));
            end
        end
        acc = 64'(biases[NL * MW]);
        for (int i = 0; i < nw; i++) begin
            acc += 64'(qmul(weights[widx(NL, i, 0)], acts[aidx(NL - 1, i)]));
        end
        acts[OUT_SLOT] = clamp32(acc);
        return acts[OUT_SLOT];
    endfunction

    // Deltas use the weights as they stood before the step.
    function automatic void backward_pass(input logic signed [31:0] e, input int nw);
        logic signed [63:0] acc;
        logic signed [31:0] a;
        deltas[OUT_SLOT] = e;
        for (int k = NL - 1; k >= 0; k--) begin
            for (int i = 0; i < nw; i++) begin
                a = acts[aidx(k, i)];
                acc = 0;
                if (k == NL - 1) begin
                    acc = 64'(qmul(weights[widx(NL, i, 0)], e));
                end else begin
                    for (int j = 0; j < nw; j++) begin
                        acc += 64'(qmul(weights[widx(k + 1, i, j)], deltas[aidx(k + 1, j)]));
                    end
                end
                deltas[aidx(k, i)] = qmul(clamp32(acc), qmul(a, Q_ONE - a));
            end
        end
    endfunction

    function automatic void sgd_update(input int nw);
        logic signed [31:0] lr;
        logic signed [31:0] a;
        logic signed [31:0] d;
        int nsrc;
        int ndst;
        int b;
        lr = rate_reg > 25'd16777216 ? Q_ONE : 32'(rate_reg);
        for (int l = 0; l <= NL; l++) begin
            nsrc = l == 0 ? 1 : nw;
            ndst = l < NL ? nw : 1;
            for (int i = 0; i < nsrc; i++) begin
                a = l == 0 ? acts[0] : acts[aidx(l - 1, i)];
                for (int j = 0; j < ndst; j++) begin
                    d = l < NL ? deltas[aidx(l, j)] : deltas[OUT_SLOT];
                    weights[widx(l, i, j)] = clamp32(64'(weights[widx(l, i, j)])
                                                     - 64'(qmul(lr, qmul(d, a))));
                end
            end
            for (int j = 0; j < ndst; j++) begin
                d = l < NL ? deltas[aidx(l, j)] : deltas[OUT_SLOT];
                b = l < NL ? l * MW + j : NL * MW;
                biases[b] = clamp32(64'(biases[b]) - 64'(qmul(lr, d)));
            end
        end
    endfunction

    function automatic result_t predict_item(input logic [111:0] w);
        result_t r;
        logic [1:0] op;
        logic [1:0] layer;
        logic [3:0] src;
        logic [3:0] dst;
        logic signed [31:0] val;
        logic signed [31:0] tgt;
        logic ok;
        int nw;
        op = w[1:0];
        layer = w[3:2];
        src = w[7:4];
        dst = w[11:8];
        val = w[43:12];
        tgt = w[107:76];
        nw = neurons_in_use();
        r = '0;
        case (op)
            OP_WRITE_WEIGHT: begin
                ok = layer <= NL;
                if (layer == 0 && src != 0) ok = 0;
                if (layer == NL && dst != 0) ok = 0;
                if (ok) weights[widx(layer, src, dst)] = val;
                else r.status = 1'b1;
            end
            OP_WRITE_BIAS: begin
                ok = layer <= NL;
                if (layer == NL && dst != 0) ok = 0;
                if (ok) biases[layer < NL ? layer * MW + dst : NL * MW] = val;
                else r.status = 1'b1;
            end
            default: begin
                r.pred = forward_pass(w[75:44], nw);
                if (op == OP_TRAIN) begin
                    r.err = clamp32(64'(signed'(r.pred)) - 64'(tgt));
                    backward_pass(r.err, nw);
                    sgd_update(nw);
                end
            end
        endcase
        return r;
    endfunction

    // Track state, predict on each accepted input word, compare each output word.
    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (!i_rst_n) begin
            foreach (weights[n]) weights[n] = '0;
            foreach (biases[n]) biases[n] = '0;
            foreach (acts[n]) acts[n] = '0;
            foreach (deltas[n]) deltas[n] = '0;
            width_reg = HIDDEN_WIDTH_RST;
            rate_reg = LEARNING_RATE_RST;
            expected_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HIDDEN_WIDTH) width_reg = i_cfg_wdata[4:0];
                else rate_reg = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) expected_q.push_back(predict_item(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[64:0];
                o_result_count <= o_result_count + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with none expected: %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || i_m_tdata[71:65] !== '0) begin
                        $display("%0t: expected pred %h err %h status %b, got %h %h %b",
                                 $time, want.pred, want.err, want.status,
                                 got.pred, got.err, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end
endmodule

FILE: sim/tb_mlp_backprop_trainer.sv
`timescale 1ns / 1ps

module tb_mlp_backprop_trainer;
    import mbt_pkg::*;

    localparam longint CYCLE_LIMIT = 12_000_000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_idx = REG_HIDDEN_WIDTH;
    logic [24:0]  cfg_wdata = '0;
    int           fail_count;
    int           pending;
    int           result_count;
    longint       cycles = 0;
    int           train_count = 0;
    bit           stall_random = 1'b1;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    mlp_backprop_trainer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    mlp_backprop_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Receiver: stalls in runs of its own, with stretches of steady acceptance.
    always @(posedge i_clk) begin
        if (!stall_random) m_tready <= 1'b1;
        else if ($urandom_range(0, 7) == 0) m_tready <= ~m_tready;
        else if ($urandom_range(0, 3) == 0) m_tready <= $urandom_range(0, 2) != 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Send one word and hold it until accepted; the gap before it is set by the caller.
    task automatic send_word(input logic [1:0] op, input logic [1:0] layer,
                             input logic [3:0] src, input logic [3:0] dst,
                             input logic [31:0] val, input logic [31:0] x,
                             input logic [31:0] tgt, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, tgt, x, val, dst, src, layer, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op == OP_TRAIN) train_count++;
    endtask

    // Stop sending, then wait until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [24:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] small_q();
        return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    endfunction

    function automatic logic [31:0] any_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return small_q();
        endcase
    endfunction

    // Load every in-use weight and bias with moderate random values.
    task automatic load_net(input int nw);
        for (int j = 0; j < nw; j++) begin
            send_word(OP_WRITE_WEIGHT, 2'd0, 4'd0, 4'(j), small_q(), 0, 0, 0);
            send_word(OP_WRITE_BIAS, 2'd0, 4'd0, 4'(j), small_q(), 0, 0, 0);
            send_word(OP_WRITE_BIAS, 2'd1, 4'd0, 4'(j), small_q(), 0, 0, 0);
            send_word(OP_WRITE_WEIGHT, 2'd2, 4'(j), 4'd0, small_q(), 0, 0, 0);
            for (int i = 0; i < nw; i++) begin
                send_word(OP_WRITE_WEIGHT, 2'd1, 4'(i), 4'(j), small_q(), 0, 0, 0);
            end
        end
        send_word(OP_WRITE_BIAS, 2'd2, 4'd0, 4'd0, small_q(), 0, 0, 0);
    endtask

    // Random phase: mostly predicts and trains, some stray writes.
    task automatic random_phase(input int count);
        int gap;
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 6);
                gap = $urandom_range(0, 12);
            end else begin
                gap = 0;
            end
            burst--;
            case ($urandom_range(0, 9))
                0, 1: send_word(2'($urandom_range(0, 1)), 2'($urandom),
                                4'($urandom), 4'($urandom), any_value(),
                                $urandom, $urandom, gap);
                2, 3, 4: send_word(OP_PREDICT, 2'($urandom), 4'($urandom), 4'($urandom),
                                   $urandom, $urandom_range(0, 3) == 0 ? any_value()
                                   : small_q(), $urandom, gap);
                default: send_word(OP_TRAIN, 2'($urandom), 4'($urandom), 4'($urandom),
                                   $urandom, $urandom_range(0, 3) == 0 ? any_value()
                                   : small_q(), $urandom_range(0, 5) == 0 ? any_value()
                                   : small_q(), gap);
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: bad indexes, extremes, each operation at reset width.
        send_word(OP_WRITE_WEIGHT, 2'd3, 4'd0, 4'd0, 32'h1234_5678, 0, 0, 0);
        send_word(OP_WRITE_WEIGHT, 2'd0, 4'd1, 4'd0, 32'h1, 0, 0, 0);
        send_word(OP_WRITE_WEIGHT, 2'd2, 4'd0, 4'd1, 32'h1, 0, 0, 0);
        send_word(OP_WRITE_BIAS, 2'd2, 4'd0, 4'd15, 32'h1, 0, 0, 0);
        send_word(OP_WRITE_BIAS, 2'd3, 4'd15, 4'd0, 32'h1, 0, 0, 0);
        send_word(OP_WRITE_WEIGHT, 2'd1, 4'd15, 4'd15, 32'h7FFF_FFFF, 0, 0, 0);
        send_word(OP_WRITE_WEIGHT, 2'd2, 4'd15, 4'd0, 32'h8000_0000, 0, 0, 0);
        send_word(OP_WRITE_WEIGHT, 2'd0, 4'd0, 4'd15, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 0);
        send_word(OP_WRITE_BIAS, 2'd2, 4'd0, 4'd0, 32'h8000_0000, 0, 0, 0);
        send_word(OP_PREDICT, 2'd3, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_word(OP_PREDICT, 2'd0, 4'd0, 4'd0, 0, 32'h8000_0000, 0, 0);
        send_word(OP_TRAIN, 2'd0, 4'd0, 4'd0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_word(OP_TRAIN, 2'd0, 4'd0, 4'd0, 0, 32'h8000_0000, 32'h8000_0000, 0);
        send_word(OP_TRAIN, 2'd3, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'h0100_0000,
                  32'hFFFF_FFFF, 0);
        wait_idle();

        // Several settings: extremes of width and rate, including out-of-range values.
        write_reg(REG_HIDDEN_WIDTH, 25'd0);
        write_reg(REG_LEARNING_RATE, 25'h1FF_FFFF);
        load_net(1);
        random_phase(60);
        wait_idle();
        write_reg(REG_HIDDEN_WIDTH, 25'd31);
        write_reg(REG_LEARNING_RATE, 25'd0);
        random_phase(20);
        wait_idle();
        write_reg(REG_HIDDEN_WIDTH, 25'd3);
        write_reg(REG_LEARNING_RATE, 25'd16777216);
        load_net(3);
        random_phase(120);
        wait_idle();
        stall_random = 1'b0;
        write_reg(REG_HIDDEN_WIDTH, 25'd2);
        write_reg(REG_LEARNING_RATE, 25'($urandom_range(0, 1 << 22)));
        load_net(2);
        random_phase(150);
        wait_idle();
        stall_random = 1'b1;
        write_reg(REG_HIDDEN_WIDTH, 25'd16);
        write_reg(REG_LEARNING_RATE, 25'd167772);
        random_phase(40);
        wait_idle();
        repeat (100) @(posedge i_clk);

        $display("Run covered %0d result words, %0d train steps, widths 1 to 16.",
                 result_count, train_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
